// ===== design/tldc_pkg.sv =====
// ----------------------------------------------------------------------------
// tldc_pkg
// Shared types and codes of the two-liquid dispenser controller.
// ----------------------------------------------------------------------------
package tldc_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_TEMP_LIMIT  = 3'd0;
    localparam logic [2:0] CFG_TANK_DEPTH  = 3'd1;
    localparam logic [2:0] CFG_SPIRIT_MS   = 3'd2;
    localparam logic [2:0] CFG_MIXER_MS    = 3'd3;
    localparam logic [2:0] CFG_NOTICE_MS   = 3'd4;

    // key codes
    localparam logic [2:0] KEY_UP     = 3'd1;
    localparam logic [2:0] KEY_DOWN   = 3'd2;
    localparam logic [2:0] KEY_SERVE  = 3'd3;
    localparam logic [2:0] KEY_EMERG  = 3'd4;

    // message codes
    localparam logic [3:0] MSG_NONE    = 4'd0;
    localparam logic [3:0] MSG_RATIO   = 4'd1;
    localparam logic [3:0] MSG_MAX     = 4'd2;
    localparam logic [3:0] MSG_MIN     = 4'd3;
    localparam logic [3:0] MSG_SERVING = 4'd4;
    localparam logic [3:0] MSG_WARM    = 4'd5;
    localparam logic [3:0] MSG_INSUF   = 4'd6;
    localparam logic [3:0] MSG_EMERG   = 4'd7;
    localparam logic [3:0] MSG_CHOOSE  = 4'd8;

    localparam int LEVEL_MAX = 200;

    typedef struct packed {
        logic [6:0]  temp_limit;
        logic [7:0]  tank_depth_cm;
        logic [11:0] spirit_ms_per_unit;
        logic [11:0] mixer_ms_per_unit;
        logic [15:0] notice_ms;
    } t_cfg;

    typedef struct packed {
        logic              mode;
        logic [2:0]        key;
        logic [7:0]        dist_mixer;
        logic [7:0]        dist_spirit;
        logic signed [7:0] temperature;
    } t_item;

    typedef struct packed {
        logic [3:0] message;
        logic       sensor_enable;
        logic       relay_mixer;
        logic       relay_spirit;
        logic [3:0] mixer_tenths;
        logic [2:0] spirit_tenths;
        logic [2:0] phase;
    } t_result;

endpackage

// ===== design/two_liquid_dispenser_controller.sv =====
// ----------------------------------------------------------------------------
// two_liquid_dispenser_controller
// Two-liquid mixing dispenser controller with stream ports.
// ----------------------------------------------------------------------------
// Each input item is a millisecond tick (tuser 0) or a key press (tuser 1)
// with the sampled tank distances and temperature; each one yields exactly
// one result item with phase, shares, relay and sensor controls and a message
// code. While the output is not stalled, the block takes one item per cycle:
// an input register and a result register stand around a combinational
// state update; an accepted item waits in the input register until the
// result register is free, and its result is then registered there.
// Configuration writes take effect at once and are always ready; write only
// while no item is in flight.
module two_liquid_dispenser_controller import tldc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [2:0] key, [10:3] dist_mixer, [18:11] dist_spirit, [26:19] temperature
    input  logic [31:0] i_s_axis_tdata,
    // [0] mode
    input  logic [0:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [2:0] phase, [5:3] spirit_tenths, [9:6] mixer_tenths, [10] relay_spirit,
    // [11] relay_mixer, [12] sensor_enable, [16:13] message
    output logic [23:0] o_m_axis_tdata
);

    t_cfg    r_cfg;
    t_item   w_item;
    t_result w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_limit         <= 7'd8;
            r_cfg.tank_depth_cm      <= 8'd20;
            r_cfg.spirit_ms_per_unit <= 12'd1000;
            r_cfg.mixer_ms_per_unit  <= 12'd1500;
            r_cfg.notice_ms          <= 16'd3000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TEMP_LIMIT: r_cfg.temp_limit         <= i_cfg_data[6:0];
                CFG_TANK_DEPTH: r_cfg.tank_depth_cm      <= i_cfg_data[7:0];
                CFG_SPIRIT_MS:  r_cfg.spirit_ms_per_unit <= i_cfg_data[11:0];
                CFG_MIXER_MS:   r_cfg.mixer_ms_per_unit  <= i_cfg_data[11:0];
                CFG_NOTICE_MS:  r_cfg.notice_ms          <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_item.mode        = i_s_axis_tuser[0];
    assign w_item.key         = i_s_axis_tdata[2:0];
    assign w_item.dist_mixer  = i_s_axis_tdata[10:3];
    assign w_item.dist_spirit = i_s_axis_tdata[18:11];
    assign w_item.temperature = $signed(i_s_axis_tdata[26:19]);

    tldc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_item   (w_item),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_res   (w_res)
    );

    assign o_m_axis_tdata = {7'd0, w_res};

endmodule

// ===== design/tldc_core.sv =====
// ----------------------------------------------------------------------------
// tldc_core
// Input register, controller state update and result register.
// ----------------------------------------------------------------------------
module tldc_core import tldc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_item   i_in_item,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_res
);

    typedef enum logic [2:0] {
        PH_STANDBY = 3'd0,
        PH_SPIRIT  = 3'd1,
        PH_MIXER   = 3'd2,
        PH_QUERY   = 3'd3,
        PH_EMERG   = 3'd4
    } t_phase;

    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    t_result     r_res;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_share, n_share;
    logic [17:0] r_cd, n_cd;
    logic        r_notice, n_notice;
    logic        r_sensor, n_sensor;
    logic [3:0]  n_msg;

    logic        w_adv;
    logic [3:0]  w_mix_share;
    logic [17:0] w_spirit_cd;
    logic [17:0] w_mixer_cd;
    logic        w_running;
    logic        w_levels_ok;
    logic        w_temp_ok;

    // (depth - distance)*10 - share*5 must lie in 1..LEVEL_MAX
    function automatic logic level_ok(logic [7:0] depth, logic [7:0] level_cm,
                                      logic [3:0] share);
        logic signed [13:0] d;
        logic signed [13:0] v;
        d = $signed({6'd0, depth}) - $signed({6'd0, level_cm});
        v = d * 14'sd10 - $signed({10'd0, share}) * 14'sd5;
        return (v > 14'sd0) && (v <= 14'(LEVEL_MAX));
    endfunction

    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_res;

    assign w_mix_share = 4'd10 - {1'b0, r_share};
    // spirit units = 5*spirit share, mixer units = 5*mixer share
    assign w_spirit_cd = 18'(6'({3'd0, r_share}) * 6'd5) * 18'(i_cfg.spirit_ms_per_unit);
    assign w_mixer_cd  = 18'(6'({2'd0, w_mix_share}) * 6'd5) * 18'(i_cfg.mixer_ms_per_unit);
    assign w_running   = (r_phase == PH_SPIRIT) || (r_phase == PH_MIXER) ||
                         (r_phase == PH_EMERG) || r_notice;
    assign w_levels_ok = level_ok(i_cfg.tank_depth_cm, r_in.dist_mixer, w_mix_share) &&
                         level_ok(i_cfg.tank_depth_cm, r_in.dist_spirit, {1'b0, r_share});
    assign w_temp_ok   = !r_in.temperature[7] &&
                         (r_in.temperature[6:0] <= i_cfg.temp_limit);

    always_comb begin
        n_phase  = r_phase;
        n_share  = r_share;
        n_cd     = r_cd;
        n_notice = r_notice;
        n_sensor = r_sensor;
        n_msg    = MSG_NONE;
        if (!r_in.mode) begin
            // millisecond tick
            if (w_running) begin
                if (r_cd > 18'd1) begin
                    n_cd = r_cd - 18'd1;
                end else if (r_phase == PH_SPIRIT) begin
                    n_phase = PH_MIXER;
                    n_cd    = w_mixer_cd;
                end else begin
                    if (r_phase == PH_EMERG) begin
                        n_sensor = 1'b1;
                    end
                    n_cd     = '0;
                    n_phase  = PH_STANDBY;
                    n_notice = 1'b0;
                    n_msg    = MSG_CHOOSE;
                end
            end
        end else begin
            priority if (r_in.key == KEY_EMERG && r_phase != PH_EMERG) begin
                n_phase  = PH_EMERG;
                n_notice = 1'b0;
                n_sensor = 1'b0;
                n_cd     = 18'(i_cfg.notice_ms);
                n_msg    = MSG_EMERG;
            end else if (r_phase == PH_QUERY) begin
                if (r_in.key == KEY_UP) begin
                    n_phase  = PH_SPIRIT;
                    n_notice = 1'b0;
                    n_cd     = w_spirit_cd;
                    n_msg    = MSG_SERVING;
                end else if (r_in.key == KEY_DOWN) begin
                    n_phase  = PH_STANDBY;
                    n_cd     = '0;
                    n_notice = 1'b0;
                    n_msg    = MSG_CHOOSE;
                end
            end else if (r_phase == PH_STANDBY) begin
                if (r_in.key == KEY_UP) begin
                    if (r_share <= 3'd4) begin
                        n_share = r_share + 3'd1;
                        n_msg   = MSG_RATIO;
                    end else begin
                        n_msg = MSG_MAX;
                    end
                end else if (r_in.key == KEY_DOWN) begin
                    if (r_share >= 3'd2) begin
                        n_share = r_share - 3'd1;
                        n_msg   = MSG_RATIO;
                    end else begin
                        n_msg = MSG_MIN;
                    end
                end else if (r_in.key == KEY_SERVE) begin
                    if (w_levels_ok) begin
                        if (w_temp_ok) begin
                            n_phase  = PH_SPIRIT;
                            n_notice = 1'b0;
                            n_cd     = w_spirit_cd;
                            n_msg    = MSG_SERVING;
                        end else begin
                            n_phase = PH_QUERY;
                            n_msg   = MSG_WARM;
                        end
                    end else begin
                        n_notice = 1'b1;
                        n_cd     = 18'(i_cfg.notice_ms);
                        n_msg    = MSG_INSUF;
                    end
                end
            end else begin
                // pouring or emergency: drop the key
                n_msg = MSG_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_STANDBY;
            r_share     <= 3'd3;
            r_cd        <= '0;
            r_notice    <= 1'b0;
            r_sensor    <= 1'b1;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_share     <= n_share;
                r_cd        <= n_cd;
                r_notice    <= n_notice;
                r_sensor    <= n_sensor;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        if (w_adv) begin
            r_res.phase         <= n_phase;
            r_res.spirit_tenths <= n_share;
            r_res.mixer_tenths  <= 4'd10 - {1'b0, n_share};
            r_res.relay_spirit  <= (n_phase == PH_SPIRIT);
            r_res.relay_mixer   <= (n_phase == PH_MIXER);
            r_res.sensor_enable <= n_sensor;
            r_res.message       <= n_msg;
        end
    end

`ifndef SYNTH
    a_emerg_sensor_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_EMERG |-> !r_sensor)
        else $error("sensor enabled during emergency");

    a_share_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_share >= 3'd1 && r_share <= 3'd5)
        else $error("spirit share out of range");

    // a pending notice survives a warm query
    a_notice_standby: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_notice |-> r_phase == PH_STANDBY || r_phase == PH_QUERY)
        else $error("notice pending outside standby or warm query");

    a_emerg_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in.mode && r_in.key == KEY_EMERG |=> r_phase == PH_EMERG)
        else $error("emergency key did not enter emergency");

    a_result_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_res.phase == r_phase && r_res.spirit_tenths == r_share)
        else $error("result does not reflect updated state");
`endif

endmodule

// ===== tb/sv/two_liquid_dispenser_controller_tb.sv =====
// ----------------------------------------------------------------------------
// two_liquid_dispenser_controller_tb
// Self-checking bench for the two-liquid dispenser controller.
// ----------------------------------------------------------------------------
// A tracker class mirrors the dispenser state (phase, spirit share, the one
// countdown, the pending notice and the sensor enable). It predicts one status
// item for every accepted input item and compares the returned status field
// by field. A short directed walk covers the share limits, the insufficient
// notice, the warm query answered both ways, and the emergency cut during a
// pour. Random phases follow under several register settings, the extremes
// among them. Both stream sides idle at random, and the status side holds off
// once for a long stretch so that the block backs up.
module two_liquid_dispenser_controller_tb;
    import tldc_pkg::*;

    localparam logic [2:0] PH_STANDBY = 3'd0;
    localparam logic [2:0] PH_SPIRIT  = 3'd1;
    localparam logic [2:0] PH_MIXER   = 3'd2;
    localparam logic [2:0] PH_QUERY   = 3'd3;
    localparam logic [2:0] PH_ALARM   = 3'd4;

    localparam logic       MODE_TICK  = 1'b0;
    localparam logic       MODE_KEY   = 1'b1;
    localparam logic [2:0] KEY_NONE   = 3'd0;
    localparam logic [2:0] KEY_SPARE  = 3'd5;
    localparam logic [2:0] CFG_SPARE  = 3'd5;

    class dispense_tracker;
        t_cfg        cfg;
        logic [2:0]  phase;
        logic [2:0]  share;
        logic [17:0] countdown;
        bit          notice_pending;
        bit          sensor_on;
        t_result     status_q[$];
        int          fault_count;
        int          status_seen;
        int          msg_tally[16];

        function new();
            cfg = '{temp_limit: 7'd8, tank_depth_cm: 8'd20, spirit_ms_per_unit: 12'd1000,
                    mixer_ms_per_unit: 12'd1500, notice_ms: 16'd3000};
            phase = PH_STANDBY;
            share = 3'd3;
            countdown = '0;
            notice_pending = 1'b0;
            sensor_on = 1'b1;
        endfunction

        function void write_reg(logic [2:0] index, logic [15:0] data);
            case (index)
                CFG_TEMP_LIMIT: cfg.temp_limit = data[6:0];
                CFG_TANK_DEPTH: cfg.tank_depth_cm = data[7:0];
                CFG_SPIRIT_MS:  cfg.spirit_ms_per_unit = data[11:0];
                CFG_MIXER_MS:   cfg.mixer_ms_per_unit = data[11:0];
                CFG_NOTICE_MS:  cfg.notice_ms = data;
                default: ;
            endcase
        endfunction

        function bit level_ok(logic [7:0] level_cm, int portion);
            int v;
            v = (int'(cfg.tank_depth_cm) - int'(level_cm)) * 10 - portion * 5;
            return v > 0 && v <= LEVEL_MAX;
        endfunction

        function void begin_pour();
            phase = PH_SPIRIT;
            notice_pending = 1'b0;
            countdown = 18'(5 * int'(share) * int'(cfg.spirit_ms_per_unit));
        endfunction

        function logic [3:0] advance_ms();
            if (phase != PH_SPIRIT && phase != PH_MIXER && phase != PH_ALARM && !notice_pending)
                return MSG_NONE;
            if (countdown > 18'd1) begin
                countdown = countdown - 18'd1;
                return MSG_NONE;
            end
            countdown = '0;
            if (phase == PH_SPIRIT) begin
                phase = PH_MIXER;
                countdown = 18'(5 * (10 - int'(share)) * int'(cfg.mixer_ms_per_unit));
                return MSG_NONE;
            end
            if (phase == PH_ALARM)
                sensor_on = 1'b1;
            phase = PH_STANDBY;
            notice_pending = 1'b0;
            return MSG_CHOOSE;
        endfunction

        function logic [3:0] press_key(logic [2:0] key, logic [7:0] dm, logic [7:0] ds,
                                       logic signed [7:0] temp);
            int t;
            t = temp;
            if (key == KEY_EMERG && phase != PH_ALARM) begin
                phase = PH_ALARM;
                notice_pending = 1'b0;
                sensor_on = 1'b0;
                countdown = 18'(cfg.notice_ms);
                return MSG_EMERG;
            end
            if (phase == PH_QUERY) begin
                if (key == KEY_UP) begin
                    begin_pour();
                    return MSG_SERVING;
                end
                if (key == KEY_DOWN) begin
                    phase = PH_STANDBY;
                    countdown = '0;
                    notice_pending = 1'b0;
                    return MSG_CHOOSE;
                end
                return MSG_NONE;
            end
            if (phase != PH_STANDBY)
                return MSG_NONE;
            case (key)
                KEY_UP: begin
                    if (share <= 3'd4) begin
                        share = share + 3'd1;
                        return MSG_RATIO;
                    end
                    return MSG_MAX;
                end
                KEY_DOWN: begin
                    if (share >= 3'd2) begin
                        share = share - 3'd1;
                        return MSG_RATIO;
                    end
                    return MSG_MIN;
                end
                KEY_SERVE: begin
                    if (level_ok(dm, 10 - int'(share)) && level_ok(ds, int'(share))) begin
                        if (t >= 0 && t <= int'(cfg.temp_limit)) begin
                            begin_pour();
                            return MSG_SERVING;
                        end
                        phase = PH_QUERY;
                        return MSG_WARM;
                    end
                    notice_pending = 1'b1;
                    countdown = 18'(cfg.notice_ms);
                    return MSG_INSUF;
                end
                default: return MSG_NONE;
            endcase
        endfunction

        function void note(logic mode, logic [2:0] key, logic [7:0] dm, logic [7:0] ds,
                           logic signed [7:0] temp);
            t_result r;
            r.message = (mode == MODE_TICK) ? advance_ms() : press_key(key, dm, ds, temp);
            r.phase = phase;
            r.spirit_tenths = share;
            r.mixer_tenths = 4'(10 - int'(share));
            r.relay_spirit = (phase == PH_SPIRIT);
            r.relay_mixer = (phase == PH_MIXER);
            r.sensor_enable = sensor_on;
            status_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [3:0] want, logic [3:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                fault_count++;
            end
        endfunction

        function void check(logic [23:0] data);
            t_result got, want;
            got = t_result'(data[16:0]);
            if (status_q.size() == 0) begin
                $display("%0t: unexpected status item, expected none, got %h", $time, data);
                fault_count++;
                return;
            end
            want = status_q.pop_front();
            status_seen++;
            msg_tally[want.message]++;
            compare_field("phase", want.phase, got.phase);
            compare_field("spirit_tenths", want.spirit_tenths, got.spirit_tenths);
            compare_field("mixer_tenths", want.mixer_tenths, got.mixer_tenths);
            compare_field("relay_spirit", want.relay_spirit, got.relay_spirit);
            compare_field("relay_mixer", want.relay_mixer, got.relay_mixer);
            compare_field("sensor_enable", want.sensor_enable, got.sensor_enable);
            compare_field("message", want.message, got.message);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;
    logic [0:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;

    dispense_tracker sb = new();
    t_cfg            cur_cfg;
    int              cycle_no = 0;
    int              settings_used = 0;

    two_liquid_dispenser_controller dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note(i_s_axis_tuser[0], i_s_axis_tdata[2:0], i_s_axis_tdata[10:3],
                        i_s_axis_tdata[18:11], i_s_axis_tdata[26:19]);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check(o_m_axis_tdata);
        end
    end

    // status side: random holds, calm stretches, and one long backlog hold
    initial begin : status_sink
        int  stall;
        bit  backlog_done;
        int  r;
        stall = 0;
        backlog_done = 1'b0;
        forever begin
            @(negedge i_clk);
            r = $urandom_range(0, 99);
            if (stall > 0) begin
                stall--;
                i_m_axis_tready <= 1'b0;
            end else if (!backlog_done && sb.status_seen >= 1000) begin
                backlog_done = 1'b1;
                stall = 400;
                i_m_axis_tready <= 1'b0;
            end else if ((cycle_no / 700) % 4 == 3 || r < 70) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b0;
                r = $urandom_range(0, 99);
                if (r < 85)
                    stall = $urandom_range(0, 3);
                else
                    stall = $urandom_range(10, 50);
            end
        end
    end

    initial begin : watchdog
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((cycle_no / 700) % 4 == 1)
            return 0;
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // enter and leave at a falling edge; valid stays high on return
    task automatic send_item(input logic mode, input logic [2:0] key, input logic [7:0] dm,
                             input logic [7:0] ds, input logic [7:0] temp);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= mode;
        i_s_axis_tdata <= {5'd0, temp, ds, dm, key};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] index, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // unused upper data bits carry junk; the block must drop them
    task automatic load_config(input t_cfg c, input bit poke_spare);
        logic [15:0] junk;
        junk = 16'($urandom);
        cfg_write(CFG_TEMP_LIMIT, {junk[15:7], c.temp_limit});
        cfg_write(CFG_TANK_DEPTH, {junk[15:8], c.tank_depth_cm});
        cfg_write(CFG_SPIRIT_MS, {junk[15:12], c.spirit_ms_per_unit});
        cfg_write(CFG_MIXER_MS, {junk[11:8], c.mixer_ms_per_unit});
        cfg_write(CFG_NOTICE_MS, c.notice_ms);
        if (poke_spare)
            cfg_write(CFG_SPARE + 3'($urandom_range(0, 2)), junk);
        i_cfg_valid <= 1'b0;
        cur_cfg = c;
        settings_used++;
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.status_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [7:0] near_level(logic [7:0] depth);
        if ($urandom_range(0, 99) < 85)
            return 8'(depth - 8'($urandom_range(0, 25)));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random(input bit allow_alarm);
        logic       mode;
        logic [2:0] key;
        logic [7:0] temp;
        int         r;
        mode = ($urandom_range(0, 99) < 40) ? MODE_KEY : MODE_TICK;
        r = $urandom_range(0, 99);
        if (r < 18)
            key = KEY_UP;
        else if (r < 36)
            key = KEY_DOWN;
        else if (r < 80)
            key = KEY_SERVE;
        else if (r < 86 && (allow_alarm || mode == MODE_TICK))
            key = KEY_EMERG;
        else if (r < 93)
            key = KEY_NONE;
        else
            key = KEY_SPARE + 3'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < 70)
            temp = 8'($urandom_range(0, (cur_cfg.temp_limit > 7'd124) ? 127
                                                 : int'(cur_cfg.temp_limit) + 3));
        else
            temp = 8'($urandom_range(0, 255));
        send_item(mode, key, near_level(cur_cfg.tank_depth_cm),
                  near_level(cur_cfg.tank_depth_cm), temp);
    endtask

    function automatic t_cfg small_config();
        t_cfg c;
        c.temp_limit = 7'($urandom_range(0, 40));
        c.tank_depth_cm = 8'($urandom_range(20, 255));
        c.spirit_ms_per_unit = 12'($urandom_range(1, 3));
        c.mixer_ms_per_unit = 12'($urandom_range(1, 3));
        c.notice_ms = 16'($urandom_range(1, 12));
        return c;
    endfunction

    task automatic run_directed();
        // walk the spirit share to both limits, then back to three
        repeat (3) send_item(MODE_KEY, KEY_UP, 8'd0, 8'd0, 8'd0);
        repeat (5) send_item(MODE_KEY, KEY_DOWN, 8'd0, 8'd0, 8'd0);
        repeat (2) send_item(MODE_KEY, KEY_UP, 8'd0, 8'd0, 8'd0);
        // mixer tank reads empty: notice raised, keys stay live, then expiry
        send_item(MODE_KEY, KEY_SERVE, 8'd255, 8'd18, 8'd5);
        send_item(MODE_KEY, KEY_UP, 8'd0, 8'd0, 8'd0);
        send_item(MODE_KEY, KEY_DOWN, 8'd0, 8'd0, 8'd0);
        repeat (3) send_item(MODE_TICK, KEY_NONE, 8'd0, 8'd0, 8'd0);
        // too warm: ask, decline, ask again from a cold reading, accept
        send_item(MODE_KEY, KEY_SERVE, 8'd16, 8'd18, 8'h7F);
        send_item(MODE_KEY, KEY_SERVE, 8'd16, 8'd18, 8'h7F);
        send_item(MODE_KEY, KEY_DOWN, 8'd0, 8'd0, 8'd0);
        send_item(MODE_KEY, KEY_SERVE, 8'd16, 8'd18, 8'h80);
        send_item(MODE_KEY, KEY_UP, 8'd0, 8'd0, 8'd0);
        // keys other than emergency are dead while pouring
        send_item(MODE_KEY, KEY_UP, 8'd0, 8'd0, 8'd0);
        send_item(MODE_TICK, KEY_NONE, 8'd0, 8'd0, 8'd0);
        send_item(MODE_KEY, KEY_EMERG, 8'd0, 8'd0, 8'd0);
        send_item(MODE_KEY, KEY_EMERG, 8'd0, 8'd0, 8'd0);
        repeat (3) send_item(MODE_TICK, KEY_NONE, 8'd0, 8'd0, 8'd0);
        // idle tick carrying key bits, then undefined key codes
        send_item(MODE_TICK, KEY_EMERG, 8'hFF, 8'hFF, 8'hFF);
        send_item(MODE_KEY, KEY_SPARE + 3'd2, 8'hFF, 8'hFF, 8'hFF);
        send_item(MODE_KEY, KEY_NONE, 8'd0, 8'd0, 8'd0);
    endtask

    initial begin : stimulus
        t_cfg c;
        int   n;
        bit   allow_alarm;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        c = '{temp_limit: 7'd8, tank_depth_cm: 8'd20, spirit_ms_per_unit: 12'd1,
              mixer_ms_per_unit: 12'd2, notice_ms: 16'd3};
        load_config(c, 1'b0);
        run_directed();
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            c = small_config();
            n = 330;
            allow_alarm = 1'b1;
            case (p)
                0: begin
                    c = '{temp_limit: 7'd8, tank_depth_cm: 8'd20, spirit_ms_per_unit: 12'd2,
                          mixer_ms_per_unit: 12'd3, notice_ms: 16'd6};
                    n = 300;
                end
                1: begin
                    c = '{temp_limit: 7'd0, tank_depth_cm: 8'd1, spirit_ms_per_unit: 12'd1,
                          mixer_ms_per_unit: 12'd1, notice_ms: 16'd1};
                    n = 150;
                end
                2: n = 300;
                3: begin
                    // long spans: keep emergency out so it cannot lock the run
                    c = '{temp_limit: 7'd127, tank_depth_cm: 8'd255,
                          spirit_ms_per_unit: 12'd4095, mixer_ms_per_unit: 12'd4095,
                          notice_ms: 16'd65535};
                    n = 120;
                    allow_alarm = 1'b0;
                end
                4: begin
                    // short spirit span reaches the longest mixer load
                    c.spirit_ms_per_unit = 12'd1;
                    c.mixer_ms_per_unit = 12'd4095;
                    c.notice_ms = 16'd2;
                    n = 130;
                end
                default: ;
            endcase
            load_config(c, p == 2 || p == 6);
            repeat (n) send_random(allow_alarm);
            wait_drained();
        end

        repeat (8) @(negedge i_clk);
        $display("Checked %0d status items under %0d register settings.",
                 sb.status_seen, settings_used);
        $display("Pours %0d, warm queries %0d, shortages %0d, emergencies %0d, returns %0d.",
                 sb.msg_tally[MSG_SERVING], sb.msg_tally[MSG_WARM], sb.msg_tally[MSG_INSUF],
                 sb.msg_tally[MSG_EMERG], sb.msg_tally[MSG_CHOOSE]);
        if (sb.fault_count == 0 && sb.status_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/tldc_pkg.sv
design/tldc_core.sv
design/two_liquid_dispenser_controller.sv
tb/sv/two_liquid_dispenser_controller_tb.sv
